// File: rtl/qoi_chunk_decoder_unit_defines.svh
`ifndef QOI_CHUNK_DECODER_UNIT_DEFINES_SVH
`define QOI_CHUNK_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define QOI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qoi check failed");

// next-cycle implication, checked while out of reset
`define QOI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qoi check failed");

`endif

// File: rtl/qoi_pkg.sv
`timescale 1ns / 1ps

package qoi_pkg;

    localparam int unsigned CACHE_DEPTH = 64;
    localparam int unsigned CACHE_AW    = 6;

    // 8-bit op tags
    localparam logic [7:0] TAG_RGB  = 8'hFE;
    localparam logic [7:0] TAG_RGBA = 8'hFF;

    // 2-bit op field in bits 7:6
    localparam logic [1:0] OP2_INDEX = 2'b00;
    localparam logic [1:0] OP2_DIFF  = 2'b01;
    localparam logic [1:0] OP2_LUMA  = 2'b10;
    localparam logic [1:0] OP2_RUN   = 2'b11;

    // pending multi-byte op
    localparam logic [1:0] PEND_RGB  = 2'd0;
    localparam logic [1:0] PEND_RGBA = 2'd1;
    localparam logic [1:0] PEND_LUMA = 2'd2;

    // kind of pixel being completed
    localparam logic [2:0] KIND_RGB   = 3'd0;
    localparam logic [2:0] KIND_RGBA  = 3'd1;
    localparam logic [2:0] KIND_LUMA  = 3'd2;
    localparam logic [2:0] KIND_INDEX = 3'd3;
    localparam logic [2:0] KIND_DIFF  = 3'd4;
    localparam logic [2:0] KIND_RUN   = 3'd5;

    localparam logic [2:0] CHANNELS_RESET = 3'd4;
    localparam logic [2:0] CHANNELS_RGBA  = 3'd4;

    typedef struct packed {
        logic accept;  // input byte transfer this cycle
        logic calc;    // build the pixel from the latched op
        logic emit;    // load output register and commit the pixel
        logic last;    // emitted pixel is the last one of this byte
    } t_dp_cmd;

    typedef struct packed {
        logic       completes;  // byte at the input finishes a pixel op
        logic [5:0] run_len;    // extra pixels of a run, zero otherwise
    } t_dp_status;

endpackage

// File: rtl/qoi_ctrl.sv
`timescale 1ns / 1ps

module qoi_ctrl
    import qoi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] r_state, n_state;
    logic [5:0] r_run_left, n_run_left;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;
    logic       w_can_emit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_can_emit  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_run_left  = r_run_left;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.accept = w_accept;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_status.completes) begin
                    n_run_left = i_status.run_len;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.last = (r_run_left == 6'd0);
                if (w_can_emit) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    if (r_run_left == 6'd0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_run_left = r_run_left - 6'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run_left  <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run_left  <= n_run_left;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/qoi_dp.sv
`timescale 1ns / 1ps

module qoi_dp
    import qoi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_byte,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    output logic [31:0] o_pixel,   // red, green, blue, alpha from bit 0 up
    output logic        o_last
);

    // pixels kept as {r, g, b, a} with red in the top byte
    logic [31:0] r_mem [CACHE_DEPTH];
    logic [CACHE_DEPTH-1:0] r_valid;
    logic [31:0] r_rd_data;
    logic        r_rd_ok;

    logic [31:0] r_prev;
    logic [2:0]  r_phase, n_phase;
    logic [1:0]  r_pend, n_pend;
    logic [23:0] r_coll, n_coll;
    logic [2:0]  r_kind, n_kind;
    logic [7:0]  r_byte, n_byte;
    logic [2:0]  r_channels;
    logic [31:0] r_px, n_px;
    logic [31:0] r_out_pixel;
    logic        r_out_last;

    logic        w_is_tag;
    logic [CACHE_AW-1:0] w_hash;

    function automatic logic [CACHE_AW-1:0] f_hash(input logic [31:0] px);
        logic [5:0] hr, hg, hb, ha;
        hr = px[29:24];
        hg = px[21:16];
        hb = px[13:8];
        ha = px[5:0];
        // only the low six bits of each channel reach a mod-64 sum
        return 6'(hr * 6'd3 + hg * 6'd5 + hb * 6'd7 + ha * 6'd11);
    endfunction

    assign w_is_tag = (i_byte == TAG_RGB) || (i_byte == TAG_RGBA);
    assign w_hash   = f_hash(r_px);

    always_comb begin
        o_status.completes = (r_phase == 3'd1) ||
                             ((r_phase == 3'd0) && !w_is_tag && (i_byte[7:6] != OP2_LUMA));
        o_status.run_len   = ((r_phase == 3'd0) && !w_is_tag && (i_byte[7:6] == OP2_RUN))
                             ? i_byte[5:0] : 6'd0;
    end

    // parser state update on an input transfer
    always_comb begin
        n_phase = r_phase;
        n_pend  = r_pend;
        n_coll  = r_coll;
        n_kind  = r_kind;
        n_byte  = r_byte;
        if (i_cmd.accept) begin
            if (r_phase != 3'd0) begin
                n_phase = r_phase - 3'd1;
                if (n_phase != 3'd0) begin
                    n_coll = {r_coll[15:0], i_byte};
                end else begin
                    // operands stay until the pixel is built; the next op reloads them
                    n_byte = i_byte;
                    n_pend = PEND_RGB;
                    if (r_pend == PEND_RGBA) begin
                        n_kind = KIND_RGBA;
                    end else if (r_pend == PEND_LUMA) begin
                        n_kind = KIND_LUMA;
                    end else begin
                        n_kind = KIND_RGB;
                    end
                end
            end else if (w_is_tag) begin
                n_pend  = (i_byte == TAG_RGBA) ? PEND_RGBA : PEND_RGB;
                n_phase = (i_byte == TAG_RGBA) ? 3'd4 : 3'd3;
                n_coll  = 24'd0;
            end else begin
                n_byte = i_byte;
                unique case (i_byte[7:6])
                    OP2_INDEX: n_kind = KIND_INDEX;
                    OP2_DIFF:  n_kind = KIND_DIFF;
                    OP2_LUMA: begin
                        n_pend  = PEND_LUMA;
                        n_phase = 3'd1;
                        n_coll  = {18'd0, i_byte[5:0]};
                    end
                    default:   n_kind = KIND_RUN;
                endcase
            end
        end
    end

    // pixel construction, 8-bit wrap on every channel
    always_comb begin
        unique case (r_kind)
            KIND_RGBA: n_px = {r_coll, r_byte};
            KIND_LUMA: begin
                n_px[31:24] = r_prev[31:24] + {2'd0, r_coll[5:0]} + {4'd0, r_byte[7:4]} - 8'd40;
                n_px[23:16] = r_prev[23:16] + {2'd0, r_coll[5:0]} - 8'd32;
                n_px[15:8]  = r_prev[15:8]  + {2'd0, r_coll[5:0]} + {4'd0, r_byte[3:0]} - 8'd40;
                n_px[7:0]   = r_prev[7:0];
            end
            KIND_INDEX: n_px = r_rd_ok ? r_rd_data : 32'd0;
            KIND_DIFF: begin
                n_px[31:24] = r_prev[31:24] + {6'd0, r_byte[5:4]} - 8'd2;
                n_px[23:16] = r_prev[23:16] + {6'd0, r_byte[3:2]} - 8'd2;
                n_px[15:8]  = r_prev[15:8]  + {6'd0, r_byte[1:0]} - 8'd2;
                n_px[7:0]   = r_prev[7:0];
            end
            KIND_RUN:  n_px = r_prev;
            default:   n_px = {r_coll[15:0], r_byte, r_prev[7:0]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= 3'd0;
            r_pend     <= PEND_RGB;
            r_coll     <= 24'd0;
            r_prev     <= {24'd0, 8'd255};
            r_channels <= CHANNELS_RESET;
        end else begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_coll  <= n_coll;
            if (i_cmd.emit) begin
                r_prev <= r_px;
            end
            if (i_cfg_we) begin
                r_channels <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_byte <= n_byte;
        if (i_cmd.calc) begin
            r_px <= n_px;
        end
        if (i_cmd.emit) begin
            r_out_pixel <= {(r_channels == CHANNELS_RGBA) ? r_px[7:0] : 8'd255,
                            r_px[15:8], r_px[23:16], r_px[31:24]};
            r_out_last  <= i_cmd.last;
        end
    end

    // colour cache: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.emit) begin
            r_valid[w_hash] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_mem[w_hash] <= r_px;
        end
        if (i_cmd.accept) begin
            r_rd_data <= r_mem[i_byte[CACHE_AW-1:0]];
            r_rd_ok   <= r_valid[i_byte[CACHE_AW-1:0]];
        end
    end

    assign o_pixel = r_out_pixel;
    assign o_last  = r_out_last;

endmodule

// File: rtl/qoi_chunk_decoder_unit.sv
// a completing byte sends the controller to build (registers the pixel), then
//   to emit (loads the output register); no byte is taken until its last pixel
//   is emitted. throughput: operand bytes 1 per cycle
// the output register takes the next pixel in the cycle the previous one leaves
// reset: synchronous, active low; cache reads as zero, previous pixel is
//   opaque black, channels is 4, parser waits for an op byte
`timescale 1ns / 1ps

module qoi_chunk_decoder_unit
    import qoi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // chunk_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // red, green, blue, alpha
    output logic        m_axis_tlast,   // last_of_run
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data      // channels
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    qoi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    qoi_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (s_axis_tdata),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_pixel    (m_axis_tdata),
        .o_last     (m_axis_tlast)
    );

endmodule

// File: rtl/qoi_chk.sv
`timescale 1ns / 1ps
`include "qoi_chunk_decoder_unit_defines.svh"

module qoi_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled pixel holds its value
    `QOI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // a pixel that is not the last of its byte means the run is still going
    `QOI_ASSERT_IMP(a_run_blocks_input, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

    // after a non-last pixel leaves, the next pixel of the run is ready at once
    `QOI_ASSERT_NXT(a_run_continues, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

endmodule

bind qoi_chunk_decoder_unit qoi_chk u_qoi_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
